// ----- rtl/pcsc_pkg.sv -----
package pcsc_pkg;

  // Fixed point format of the pixel channels
  localparam int FRAC_BITS = 15;
  localparam int FIELD_W   = 17;
  localparam int COEF_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE >> 1;

  // Pipeline shape
  localparam int FRONT_STAGES = 5;
  localparam int DIV_STEPS    = FRAC_BITS + 1;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STEPS;

  // Divider widths: hue numerator/divisor and saturation divisor
  localparam int HN_W = FIELD_W + 3;
  localparam int SD_W = FIELD_W;

  // Stream and register port widths
  localparam int DATA_W = ((3 * FIELD_W + 7) / 8) * 8;
  localparam int ADDR_W = 3;

  localparam logic [0:0] REG_CONVERSION_MODE = 1'b0;

  // Colour coefficients, 16 fraction bits
  localparam logic signed [17:0] K_YR  = 18'sd13933;
  localparam logic signed [17:0] K_YG  = 18'sd46871;
  localparam logic signed [17:0] K_YB  = 18'sd4732;
  localparam logic signed [17:0] K_CR  = 18'sd46727;
  localparam logic signed [17:0] K_CB  = 18'sd36962;
  localparam logic signed [17:0] K_RCR = 18'sd91947;
  localparam logic signed [17:0] K_GCR = 18'sd46793;
  localparam logic signed [17:0] K_GCB = 18'sd22544;
  localparam logic signed [17:0] K_BCB = 18'sd116195;

  localparam logic signed [39:0] FIELD_MIN = -(40'sd1 <<< (FIELD_W - 1));
  localparam logic signed [39:0] FIELD_MAX = (40'sd1 <<< (FIELD_W - 1)) - 40'sd1;

  typedef enum logic [2:0] {
    MODE_SWAP      = 3'd0,
    MODE_RGB2HSV   = 3'd1,
    MODE_HSV2RGB   = 3'd2,
    MODE_RGB2YCRCB = 3'd3,
    MODE_YCRCB2RGB = 3'd4,
    MODE_RGB2GRAY  = 3'd5
  } mode_e;

  typedef logic signed [FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t ch0;
    field_t ch1;
    field_t ch2;
    logic   last;
  } pixel_t;

  typedef struct packed {
    pixel_t pix;
    logic   is_hsv;
    logic   hz;
    logic   ssat;
    logic   szero;
  } pass_t;

  typedef struct packed {
    pass_t                p;
    logic [HN_W-1:0]      h_rem;
    logic [HN_W-1:0]      h_den;
    logic [DIV_STEPS-1:0] h_quo;
    logic [SD_W-1:0]      s_rem;
    logic [SD_W-1:0]      s_den;
    logic [DIV_STEPS-1:0] s_quo;
    logic [DIV_STEPS-1:0] s_num;
  } div_t;

  function automatic logic signed [39:0] rnd_coef(input logic signed [39:0] x);
    return (x + (40'sd1 <<< (COEF_BITS - 1))) >>> COEF_BITS;
  endfunction

  function automatic logic signed [39:0] rnd_frac(input logic signed [39:0] x);
    return (x + (40'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic field_t sat_field(input logic signed [39:0] x);
    if (x < FIELD_MIN) return FIELD_MIN[FIELD_W-1:0];
    if (x > FIELD_MAX) return FIELD_MAX[FIELD_W-1:0];
    return x[FIELD_W-1:0];
  endfunction

  function automatic field_t clamp_unit(input logic signed [39:0] x);
    if (x < 40'sd0) return '0;
    if (x > 40'(ONE)) return FIELD_W'(ONE);
    return x[FIELD_W-1:0];
  endfunction

endpackage

// ----- rtl/pixel_color_space_converter.sv -----
// Pixel colour space converter.
// Slave stream: one pixel per transfer, tdata holds channel 0, 1 and 2 as
// signed Q2.15 (17 bits each, channel 0 lowest), tlast marks the final pixel
// of an image and is passed on untouched. Master stream carries the converted
// pixel in the same layout.
// The APB port holds one register, conversion_mode at address 0: 0 swap,
// 1 RGB to HSV, 2 HSV to RGB, 3 RGB to YCrCb, 4 YCrCb to RGB, 5 gray; other
// codes pass the pixel through. Write it only while no pixel is in flight.
// Throughput is one pixel per clock while the output buffer has room. From
// the input transfer to the output data being shown, the pixel passes five
// arithmetic stages and sixteen divider stages (one quotient bit of hue and
// saturation per stage) and is then written into the output buffer. The
// divider chain sets the depth.
// The output buffer holds two pixels, so the pipeline keeps accepting while
// one result waits for the receiver. When the buffer is full the whole
// pipeline holds and tready drops; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and the buffer and
// sets conversion_mode to swap.
module pixel_color_space_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // channel 0, channel 1, channel 2, zero padding
  input  logic [pcsc_pkg::DATA_W-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // channel 0, channel 1, channel 2, zero padding
  output logic [pcsc_pkg::DATA_W-1:0]   m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pcsc_pkg::*;

  // Configuration register
  logic [2:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SWAP;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CONVERSION_MODE)) begin
      mode_q <= pwdata[2:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CONVERSION_MODE) ? {29'd0, mode_q} : 32'd0;

  // Pipeline control: every stage advances together while the buffer has room
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [1:0]            cnt_q;
  logic                  en;
  logic                  push, pop;

  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;
  assign push          = en && vld_q[PIPE_DEPTH-1];
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // Datapath
  pixel_t pix_in;
  div_t   front_out, div_out;

  always_comb begin
    pix_in.ch0  = s_axis_tdata[FIELD_W-1:0];
    pix_in.ch1  = s_axis_tdata[2*FIELD_W-1:FIELD_W];
    pix_in.ch2  = s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
    pix_in.last = s_axis_tlast;
  end

  pcsc_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .pix_i  (pix_in),
    .mode_i (mode_q),
    .div_o  (front_out)
  );

  pcsc_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .div_i (front_out),
    .div_o (div_out)
  );

  // Merge the hue and saturation quotients into an HSV result
  pixel_t res;

  always_comb begin
    res = div_out.p.pix;
    if (div_out.p.is_hsv && !div_out.p.hz) begin
      res.ch0 = FIELD_W'(div_out.h_quo[DIV_STEPS-1:1]);
      if (div_out.p.szero) res.ch1 = '0;
      else if (div_out.p.ssat) res.ch1 = {1'b0, {(FIELD_W-1){1'b1}}};
      else res.ch1 = FIELD_W'(div_out.s_quo);
    end
  end

  // Two-entry output buffer, head in slot 0
  pixel_t slot0_q, slot1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push && !pop) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && pop) begin
      slot0_q <= res;
    end else if (push) begin
      if (cnt_q == 2'd0) slot0_q <= res;
      else slot1_q <= res;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {{(DATA_W-3*FIELD_W){1'b0}}, slot0_q.ch2, slot0_q.ch1, slot0_q.ch0};
  assign m_axis_tlast  = slot0_q.last;

`ifndef SYNTHESIS
  a_hue_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[PIPE_DEPTH-1] && div_out.p.is_hsv && !div_out.p.hz) |->
      (res.ch0[FIELD_W-1:FRAC_BITS] == '0))
    else $error("hue reached one");

  a_stall_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && (cnt_q == 2'd2)))
    else $error("input held back without waiting results");

  a_buffer_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == 2'd1) && pop && !push) |=> !m_axis_tvalid)
    else $error("output buffer did not drain");
`endif

endmodule

// ----- rtl/pcsc_front.sv -----
module pcsc_front (
  input  logic             clk_i,
  input  logic             en_i,
  input  pcsc_pkg::pixel_t pix_i,
  input  logic [2:0]       mode_i,
  output pcsc_pkg::div_t   div_o
);
  import pcsc_pkg::*;

  localparam int H6_W = FRAC_BITS + 3;
  localparam int HN_SW = HN_W + 1;
  localparam int OQ_W = FIELD_W + 3;

  typedef struct packed {
    logic                 hz;
    logic                 ssat;
    logic                 szero;
    logic [HN_W-1:0]      h_rem;
    logic [HN_W-1:0]      h_den;
    logic [SD_W-1:0]      s_rem;
    logic [SD_W-1:0]      s_den;
    logic [DIV_STEPS-1:0] s_num;
  } hset_t;

  // stage 1: input register
  pixel_t     pix1_q;
  logic [2:0] mode1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix1_q  <= pix_i;
      mode1_q <= mode_i;
    end
  end

  // stage 2: extremes, products, hue sector
  field_t                 mx, mn;
  logic                   sel_r, sel_g;
  logic signed [17:0]     cr, cb, oms;
  logic [H6_W-1:0]        h6;
  logic signed [34:0]     yr, yg, yb;
  logic signed [35:0]     rcr, gcr, gcb, bcb;

  pixel_t                 pix2_q;
  logic [2:0]             mode2_q;
  field_t                 mx2_q, mn2_q;
  logic                   selr2_q, selg2_q;
  logic signed [34:0]     yr2_q, yg2_q, yb2_q;
  logic signed [35:0]     rcr2_q, gcr2_q, gcb2_q, bcb2_q;
  logic [2:0]             sec2_q;
  logic [FRAC_BITS-1:0]   f2_q;
  logic signed [17:0]     oms2_q;

  always_comb begin
    sel_r = (pix1_q.ch0 >= pix1_q.ch1) && (pix1_q.ch0 >= pix1_q.ch2);
    sel_g = !sel_r && (pix1_q.ch1 >= pix1_q.ch2);
    mx = sel_r ? pix1_q.ch0 : (sel_g ? pix1_q.ch1 : pix1_q.ch2);
    if ((pix1_q.ch0 <= pix1_q.ch1) && (pix1_q.ch0 <= pix1_q.ch2)) mn = pix1_q.ch0;
    else if (pix1_q.ch1 <= pix1_q.ch2) mn = pix1_q.ch1;
    else mn = pix1_q.ch2;
    cr  = 18'(pix1_q.ch1) - 18'(HALF);
    cb  = 18'(pix1_q.ch2) - 18'(HALF);
    oms = 18'(ONE) - 18'(pix1_q.ch1);
    h6  = H6_W'(pix1_q.ch0[FRAC_BITS-1:0]) * H6_W'(6);
    yr  = pix1_q.ch0 * K_YR;
    yg  = pix1_q.ch1 * K_YG;
    yb  = pix1_q.ch2 * K_YB;
    rcr = cr * K_RCR;
    gcr = cr * K_GCR;
    gcb = cb * K_GCB;
    bcb = cb * K_BCB;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix2_q  <= pix1_q;
      mode2_q <= mode1_q;
      mx2_q   <= mx;
      mn2_q   <= mn;
      selr2_q <= sel_r;
      selg2_q <= sel_g;
      yr2_q   <= yr;
      yg2_q   <= yg;
      yb2_q   <= yb;
      rcr2_q  <= rcr;
      gcr2_q  <= gcr;
      gcb2_q  <= gcb;
      bcb2_q  <= bcb;
      sec2_q  <= h6[H6_W-1:FRAC_BITS];
      f2_q    <= h6[FRAC_BITS-1:0];
      oms2_q  <= oms;
    end
  end

  // stage 3: luma, YCrCb inverse, hsv partial products, divider set-up
  logic signed [39:0]     ysum;
  logic signed [17:0]     omf;
  logic [17:0]            delta, mx_x2;
  logic [HN_W-1:0]        d2, d4, d6;
  logic signed [HN_SW-1:0] nn;
  logic                   mx_pos;
  hset_t                  hs;

  pixel_t                 pix3_q;
  logic [2:0]             mode3_q;
  logic signed [17:0]     y3_q;
  field_t                 r3_q, g3_q, b3_q;
  logic signed [34:0]     sf3_q;
  logic signed [35:0]     sof3_q, p3_q;
  logic [2:0]             sec3_q;
  hset_t                  hs3_q;
  field_t                 mx3_q;

  always_comb begin
    ysum   = 40'(yr2_q) + 40'(yg2_q) + 40'(yb2_q);
    omf    = 18'(ONE) - $signed({3'b000, f2_q});
    delta  = 18'(mx2_q) - 18'(mn2_q);
    d2     = HN_W'({delta, 1'b0});
    d4     = HN_W'({delta, 2'b00});
    d6     = HN_W'(delta) * HN_W'(6);
    if (selr2_q) begin
      nn = HN_SW'(pix2_q.ch1) - HN_SW'(pix2_q.ch2);
      if (nn < 0) nn = nn + $signed({1'b0, d6});
    end else if (selg2_q) begin
      nn = $signed({1'b0, d2}) + HN_SW'(pix2_q.ch2) - HN_SW'(pix2_q.ch0);
    end else begin
      nn = $signed({1'b0, d4}) + HN_SW'(pix2_q.ch0) - HN_SW'(pix2_q.ch1);
    end
    mx_pos   = !mx2_q[FIELD_W-1] && (mx2_q != '0);
    mx_x2    = {1'b0, mx2_q[FIELD_W-2:0], 1'b0};
    hs.hz    = (delta == '0);
    hs.szero = !mx_pos;
    hs.ssat  = mx_pos && (delta >= mx_x2);
    hs.h_rem = nn[HN_W-1:0];
    hs.h_den = d6;
    hs.s_rem = delta[17:1];
    hs.s_den = mx2_q;
    hs.s_num = {delta[0], {(DIV_STEPS-1){1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix3_q  <= pix2_q;
      mode3_q <= mode2_q;
      y3_q    <= 18'(rnd_coef(ysum));
      r3_q    <= clamp_unit(40'(pix2_q.ch0) + rnd_coef(40'(rcr2_q)));
      g3_q    <= clamp_unit(40'(pix2_q.ch0) + rnd_coef(-40'(gcr2_q) - 40'(gcb2_q)));
      b3_q    <= clamp_unit(40'(pix2_q.ch0) + rnd_coef(40'(bcb2_q)));
      sf3_q   <= pix2_q.ch1 * $signed({1'b0, f2_q});
      sof3_q  <= pix2_q.ch1 * omf;
      p3_q    <= pix2_q.ch2 * oms2_q;
      sec3_q  <= sec2_q;
      hs3_q   <= hs;
      mx3_q   <= mx2_q;
    end
  end

  // stage 4: q and t products, chroma products
  logic signed [OQ_W-1:0] oq, ot;
  logic signed [18:0]     amy, cmy;

  pixel_t                 pix4_q;
  logic [2:0]             mode4_q;
  logic signed [17:0]     y4_q;
  field_t                 r4_q, g4_q, b4_q;
  logic signed [36:0]     q4_q, t4_q, crp4_q, cbp4_q;
  logic signed [19:0]     p4_q;
  logic [2:0]             sec4_q;
  hset_t                  hs4_q;
  field_t                 mx4_q;

  always_comb begin
    oq  = OQ_W'(40'(ONE) - rnd_frac(40'(sf3_q)));
    ot  = OQ_W'(40'(ONE) - rnd_frac(40'(sof3_q)));
    amy = 19'(pix3_q.ch0) - 19'(y3_q);
    cmy = 19'(pix3_q.ch2) - 19'(y3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix4_q  <= pix3_q;
      mode4_q <= mode3_q;
      y4_q    <= y3_q;
      r4_q    <= r3_q;
      g4_q    <= g3_q;
      b4_q    <= b3_q;
      q4_q    <= pix3_q.ch2 * oq;
      t4_q    <= pix3_q.ch2 * ot;
      p4_q    <= 20'(rnd_frac(40'(p3_q)));
      crp4_q  <= amy * K_CR;
      cbp4_q  <= cmy * K_CB;
      sec4_q  <= sec3_q;
      hs4_q   <= hs3_q;
      mx4_q   <= mx3_q;
    end
  end

  // stage 5: final result for every mode but the hsv divisions
  field_t vq, vt, vp, yv;
  pixel_t res;
  div_t   div_d, div_q;

  always_comb begin
    vq = sat_field(rnd_frac(40'(q4_q)));
    vt = sat_field(rnd_frac(40'(t4_q)));
    vp = sat_field(40'(p4_q));
    yv = sat_field(40'(y4_q));
    res = pix4_q;
    case (mode4_q)
      MODE_SWAP: begin
        res.ch0 = pix4_q.ch2;
        res.ch2 = pix4_q.ch0;
      end
      MODE_RGB2HSV: begin
        res.ch0 = '0;
        res.ch1 = '0;
        res.ch2 = mx4_q;
      end
      MODE_HSV2RGB: begin
        res.ch0 = pix4_q.ch2;
        res.ch1 = pix4_q.ch2;
        if (!pix4_q.ch1[FIELD_W-1] && (pix4_q.ch1 != '0)) begin
          case (sec4_q)
            3'd1: begin res.ch0 = vq; res.ch2 = vp; end
            3'd2: begin res.ch0 = vp; res.ch2 = vt; end
            3'd3: begin res.ch0 = vp; res.ch1 = vq; end
            3'd4: begin res.ch0 = vt; res.ch1 = vp; end
            3'd5: begin res.ch1 = vp; res.ch2 = vq; end
            default: begin res.ch1 = vt; res.ch2 = vp; end
          endcase
        end else begin
          res.ch2 = pix4_q.ch2;
        end
      end
      MODE_RGB2YCRCB: begin
        res.ch0 = yv;
        res.ch1 = sat_field(rnd_coef(40'(crp4_q)) + 40'(HALF));
        res.ch2 = sat_field(rnd_coef(40'(cbp4_q)) + 40'(HALF));
      end
      MODE_YCRCB2RGB: begin
        res.ch0 = r4_q;
        res.ch1 = g4_q;
        res.ch2 = b4_q;
      end
      MODE_RGB2GRAY: begin
        res.ch0 = yv;
        res.ch1 = yv;
        res.ch2 = yv;
      end
      default: res = pix4_q;
    endcase
    div_d.p.pix    = res;
    div_d.p.is_hsv = (mode4_q == MODE_RGB2HSV);
    div_d.p.hz     = hs4_q.hz;
    div_d.p.ssat   = hs4_q.ssat;
    div_d.p.szero  = hs4_q.szero;
    div_d.h_rem    = hs4_q.h_rem;
    div_d.h_den    = hs4_q.h_den;
    div_d.h_quo    = '0;
    div_d.s_rem    = hs4_q.s_rem;
    div_d.s_den    = hs4_q.s_den;
    div_d.s_quo    = '0;
    div_d.s_num    = hs4_q.s_num;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

// ----- rtl/pcsc_div.sv -----
module pcsc_div (
  input  logic           clk_i,
  input  logic           en_i,
  input  pcsc_pkg::div_t div_i,
  output pcsc_pkg::div_t div_o
);
  import pcsc_pkg::*;

  // One quotient bit of hue and of saturation per stage
  function automatic div_t div_step(input div_t x);
    logic [HN_W:0] hr;
    logic [SD_W:0] sr;
    div_t          y;
    y  = x;
    hr = {x.h_rem, 1'b0};
    if (hr >= {1'b0, x.h_den}) begin
      y.h_rem = HN_W'(hr - {1'b0, x.h_den});
      y.h_quo = {x.h_quo[DIV_STEPS-2:0], 1'b1};
    end else begin
      y.h_rem = hr[HN_W-1:0];
      y.h_quo = {x.h_quo[DIV_STEPS-2:0], 1'b0};
    end
    sr = {x.s_rem, x.s_num[DIV_STEPS-1]};
    if (sr >= {1'b0, x.s_den}) begin
      y.s_rem = SD_W'(sr - {1'b0, x.s_den});
      y.s_quo = {x.s_quo[DIV_STEPS-2:0], 1'b1};
    end else begin
      y.s_rem = sr[SD_W-1:0];
      y.s_quo = {x.s_quo[DIV_STEPS-2:0], 1'b0};
    end
    y.s_num = {x.s_num[DIV_STEPS-2:0], 1'b0};
    return y;
  endfunction

  div_t stg_q [DIV_STEPS];
  div_t stg_d [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign stg_d[k] = div_step(div_i);
    end else begin : g_next
      assign stg_d[k] = div_step(stg_q[k-1]);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign div_o = stg_q[DIV_STEPS-1];

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import pcsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic signed [16:0] c0;
    logic signed [16:0] c1;
    logic signed [16:0] c2;
    logic               last;
  } tb_pix_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DATA_W-1:0]   m_axis_tdata;
  logic                m_axis_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Converter state mirrored on the bench side
  logic [2:0] mode_shadow = MODE_SWAP;
  tb_pix_t    expected_pixels[$];
  int         error_count = 0;
  int         idle_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  always #5 clk_i = ~clk_i;

  pixel_color_space_converter u_dut (.*);

  // Arithmetic helpers at 64 bits, floor semantics on the shifts
  function automatic longint round_shift(longint x, int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint saturate(longint x);
    if (x < -65536) return -65536;
    if (x > 65535) return 65535;
    return x;
  endfunction

  function automatic longint unit_clamp(longint x);
    if (x < 0) return 0;
    if (x > 32768) return 32768;
    return x;
  endfunction

  function automatic longint luma_of(longint r, longint g, longint b);
    return round_shift(13933 * r + 46871 * g + 4732 * b, 16);
  endfunction

  function automatic tb_pix_t convert_pixel(tb_pix_t px);
    longint  a, b, c, y, mx, mn, dl, n, hw, h6, f, p, q, t, cr, cb;
    longint  o[3];
    tb_pix_t res;
    a = px.c0; b = px.c1; c = px.c2;
    case (mode_shadow)
      MODE_SWAP: begin
        o[0] = c; o[1] = b; o[2] = a;
      end
      MODE_RGB2HSV: begin
        mx = a; mn = a;
        if (b > mx) mx = b;
        if (c > mx) mx = c;
        if (b < mn) mn = b;
        if (c < mn) mn = c;
        dl = mx - mn;
        o[2] = mx;
        if (dl == 0) begin
          o[0] = 0; o[1] = 0;
        end else begin
          // truncating division, as in C; all operands here are non-negative
          o[1] = (mx > 0) ? (dl * 32768) / mx : 0;
          if (mx == a) begin
            n = b - c;
            if (n < 0) n += 6 * dl;
          end else if (mx == b) begin
            n = 2 * dl + (c - a);
          end else begin
            n = 4 * dl + (a - b);
          end
          o[0] = (n * 32768) / (6 * dl);
        end
      end
      MODE_HSV2RGB: begin
        if (b <= 0) begin
          o[0] = c; o[1] = c; o[2] = c;
        end else begin
          hw = a & 32767;
          h6 = hw * 6;
          f  = h6 & 32767;
          p  = round_shift(c * (32768 - b), 15);
          q  = round_shift(c * (32768 - round_shift(b * f, 15)), 15);
          t  = round_shift(c * (32768 - round_shift(b * (32768 - f), 15)), 15);
          case (h6 >>> 15)
            1: begin o[0] = q; o[1] = c; o[2] = p; end
            2: begin o[0] = p; o[1] = c; o[2] = t; end
            3: begin o[0] = p; o[1] = q; o[2] = c; end
            4: begin o[0] = t; o[1] = p; o[2] = c; end
            5: begin o[0] = c; o[1] = p; o[2] = q; end
            default: begin o[0] = c; o[1] = t; o[2] = p; end
          endcase
        end
      end
      MODE_RGB2YCRCB: begin
        y = luma_of(a, b, c);
        o[0] = y;
        o[1] = round_shift((a - y) * 46727, 16) + 16384;
        o[2] = round_shift((c - y) * 36962, 16) + 16384;
      end
      MODE_YCRCB2RGB: begin
        cr = b - 16384; cb = c - 16384;
        o[0] = unit_clamp(a + round_shift(91947 * cr, 16));
        o[1] = unit_clamp(a + round_shift(-46793 * cr - 22544 * cb, 16));
        o[2] = unit_clamp(a + round_shift(116195 * cb, 16));
      end
      MODE_RGB2GRAY: begin
        y = luma_of(a, b, c);
        o[0] = y; o[1] = y; o[2] = y;
      end
      default: begin
        o[0] = a; o[1] = b; o[2] = c;
      end
    endcase
    res.c0 = 17'(saturate(o[0]));
    res.c1 = 17'(saturate(o[1]));
    res.c2 = 17'(saturate(o[2]));
    res.last = px.last;
    return res;
  endfunction

  // Send one pixel, honouring the sender idle ratio; tvalid stays high after
  // the transfer so the next pixel can follow in the very next cycle
  task automatic send_pixel(tb_pix_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'({px.c2, px.c1, px.c0});
    s_axis_tlast  <= px.last;
    expected_pixels.push_back(convert_pixel(px));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_fields(int c0, int c1, int c2, bit last);
    tb_pix_t px;
    px.c0 = 17'(c0); px.c1 = 17'(c1); px.c2 = 17'(c2); px.last = last;
    send_pixel(px);
  endtask

  // Drop tvalid, wait until every result is back plus the pipeline latency,
  // then write mode
  task automatic set_mode(logic [2:0] mode);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(REG_CONVERSION_MODE) << 2;
    pwdata  <= 32'(mode);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mode_shadow = mode;
    @(posedge clk_i);
  endtask

  // Receiver: stall at random, check each transfer against the oldest expectation
  always @(posedge clk_i) begin
    tb_pix_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.c0 = m_axis_tdata[16:0];
        got.c1 = m_axis_tdata[33:17];
        got.c2 = m_axis_tdata[50:34];
        got.last = m_axis_tlast;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel %0d %0d %0d last %0b", $time,
                   got.c0, got.c1, got.c2, got.last);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.c0 !== want.c0 || got.c1 !== want.c1 || got.c2 !== want.c2 ||
              got.last !== want.last) begin
            $display("%0t: mode %0d expected %0d %0d %0d last %0b, actual %0d %0d %0d last %0b",
                     $time, mode_shadow, want.c0, want.c1, want.c2, want.last,
                     got.c0, got.c1, got.c2, got.last);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no transfer on either stream and no APB access
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pixel_color_space_converter verification failed");
      $finish;
    end
  end

  function automatic int rand_field();
    return $urandom_range(3) == 0 ? int'($urandom_range(65535)) - 65536 + 2 * int'($urandom_range(1))
                                  : int'($urandom_range(131071)) - 65536;
  endfunction

  // Mostly in-range pixels, some over the full field
  function automatic int rand_channel();
    case ($urandom_range(9))
      0, 1:    return rand_field();
      2:       return $urandom_range(1) ? 0 : 32768;
      default: return $urandom_range(32768);
    endcase
  endfunction

  task automatic test_directed();
    logic [2:0] m;
    for (int k = 0; k < 8; k++) begin
      m = 3'(k);
      set_mode(m);
      send_fields(0, 0, 0, 0);
      send_fields(65535, 65535, 65535, 1);
      send_fields(-65536, -65536, -65536, 0);
      send_fields(65535, -65536, 0, 1);
      send_fields(20000, 20000, 20000, 0);      // grey: zero delta
      send_fields(-100, -500, -300, 0);         // non-positive max
      send_fields(-40000, 0, 32768, 1);         // zero saturation / negative hue
      send_fields(70000 - 131072, 16384, 16384, 0);
      send_fields(32767, 32768, 1, 0);
    end
  endtask

  task automatic test_random(int count);
    tb_pix_t px;
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 0) set_mode(3'($urandom_range(7)));
      px.c0 = 17'(rand_channel());
      px.c1 = 17'(rand_channel());
      px.c2 = 17'(rand_channel());
      px.last = 1'($urandom_range(1));
      send_pixel(px);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_directed();
    send_idle_pct = 31; recv_idle_pct = 87;
    test_random(580);
    send_idle_pct = 87; recv_idle_pct = 31;
    test_random(580);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(580);
    set_mode(MODE_SWAP);
    if (error_count == 0)
      $display("pixel_color_space_converter verification clean");
    else
      $display("pixel_color_space_converter verification failed");
    $finish;
  end

endmodule
